// ----- rtl/rgm_pkg.sv -----
// shared types and constants for the relative gradient magnitude block
// no dependencies; used by rgm_ctrl, rgm_dp and the top level
package rgm_pkg;

  localparam int unsigned MAG_BITS = 16;
  localparam logic [MAG_BITS-1:0] MAG_MAX = 16'd32768;
  localparam int unsigned ROOT_FRAC2 = 30;  // radicand is scaled by 2^30
  localparam int unsigned LW_BITS = 12;
  localparam int unsigned FH_BITS = 13;
  localparam int unsigned THR_BITS = 18;
  localparam logic [FH_BITS-1:0] MAX_HEIGHT = 13'd4096;

  typedef enum logic [1:0] {
    REG_LINE_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_SUM_THRESHOLD = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_NEXT,
    ST_PREP,
    ST_SQR,
    ST_ROOT,
    ST_DLOAD,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic update;
    logic prep;
    logic sq_load;
    logic zero;
    logic root_step;
    logic div_load;
    logic div_step;
    logic finish;
    logic pop;
  } cmd_t;

  typedef struct packed {
    logic match;
    logic pending;
    logic below;
    logic root_last;
    logic div_last;
  } sts_t;

endpackage

// ----- rtl/rgm_ctrl.sv -----
// sequencer for the relative gradient magnitude block
// depends on rgm_pkg; drives commands into rgm_dp
module rgm_ctrl
  import rgm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd,
  output logic in_stall,
  output logic out_valid
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && sts.match) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: state_nxt = ST_NEXT;
      ST_NEXT: begin
        state_nxt = sts.pending ? ST_PREP : ST_IDLE;
      end
      ST_PREP: state_nxt = ST_SQR;
      ST_SQR: begin
        state_nxt = sts.below ? ST_OUT : ST_ROOT;
      end
      ST_ROOT: begin
        if (sts.root_last) state_nxt = ST_DLOAD;
      end
      ST_DLOAD: state_nxt = ST_DIV;
      ST_DIV: begin
        if (sts.div_last) state_nxt = ST_FIN;
      end
      ST_FIN: state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_stall) state_nxt = ST_NEXT;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.accept = in_valid;
      end
      ST_UPDATE: cmd.update = 1'b1;
      ST_PREP: cmd.prep = 1'b1;
      ST_SQR: begin
        cmd.sq_load = 1'b1;
        cmd.zero = sts.below;
      end
      ST_ROOT: cmd.root_step = 1'b1;
      ST_DLOAD: cmd.div_load = 1'b1;
      ST_DIV: cmd.div_step = 1'b1;
      ST_FIN: cmd.finish = 1'b1;
      ST_OUT: begin
        out_valid = 1'b1;
        cmd.pop = !out_stall;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- rtl/rgm_dp.sv -----
// datapath: line stores, window, counters, iterative square root and divider
// depends on rgm_pkg; sequenced by rgm_ctrl
module rgm_dp
  import rgm_pkg::*;
#(
  parameter int MAX_WIDTH = 2048,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic                  restart,
  input  logic [LW_BITS-1:0]    line_width,
  input  logic [FH_BITS-1:0]    frame_height,
  input  logic [THR_BITS-1:0]   sum_threshold,
  input  logic                  in_mode,
  input  logic [15:0]           in_luma,
  output logic [MAG_BITS-1:0]   magnitude,
  output logic                  end_of_line,
  output logic                  end_of_frame
);

  localparam int SB   = SAMPLE_BITS;
  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int LWX  = (WW > LW_BITS) ? WW : LW_BITS;
  localparam int SUMW = SB + 2;
  localparam int CMPW = (SUMW > THR_BITS) ? SUMW : THR_BITS;
  localparam int NP   = SB + 16;          // root bits
  localparam int SW   = 2 * SB + 2;       // dx^2 + dy^2
  localparam int SXW  = 2 * NP;
  localparam int RW   = NP + 3;
  localparam int NQ   = NP + 2;           // quotient bits
  localparam int DW   = SB + 3;           // 2 * sum
  localparam int CNTW = $clog2(NQ + 1);

  typedef logic [SB-1:0] smp_t;

  // line stores
  smp_t up_mem [MAX_WIDTH];
  smp_t mid_mem [MAX_WIDTH];
  smp_t up_rd_r, mid_rd_r;

  smp_t luma_r;
  smp_t w1_r, w2_r, w3_r, w4_r;
  logic [AW-1:0]      col_r;
  logic [FH_BITS-1:0] row_r;

  // pending results: operands left, right, up, down
  smp_t a_l_r, a_r_r, a_t_r, a_d_r;
  smp_t b_l_r, b_r_r, b_t_r, b_d_r;
  logic b_eof_r;
  logic [1:0] pend_r;

  smp_t adx_r, ady_r;
  logic [SUMW-1:0] sum_r;
  logic eol_r, eof_r;

  logic [SXW-1:0]  sx_r;
  logic [NP-1:0]   root_r;
  logic [RW-1:0]   rem_r;
  logic [NQ-1:0]   q_r;
  logic [DW-1:0]   rm_r;
  logic [CNTW-1:0] cnt_r;
  logic [MAG_BITS-1:0] mag_r;

  logic [LWX-1:0]     lw_x;
  logic [WW-1:0]      ew;
  logic [FH_BITS-1:0] eh;
  logic flushing, last, row0;
  smp_t m, u, d;

  always_comb begin
    lw_x = LWX'(line_width);
    if (line_width == '0) ew = WW'(1);
    else if (lw_x > LWX'(MAX_WIDTH)) ew = WW'(MAX_WIDTH);
    else ew = lw_x[WW-1:0];
    if (frame_height == '0) eh = FH_BITS'(1);
    else if (frame_height > MAX_HEIGHT) eh = MAX_HEIGHT;
    else eh = frame_height;
  end

  assign flushing = row_r >= eh;
  assign last     = (WW'(col_r) + WW'(1)) == ew;
  assign row0     = (row_r == '0) && !flushing;
  assign m        = mid_rd_r;
  assign u        = up_rd_r;
  assign d        = flushing ? m : luma_r;

  always_ff @(posedge clk) begin
    up_rd_r  <= up_mem[col_r];
    mid_rd_r <= mid_mem[col_r];
    if (cmd.update && !flushing) begin
      up_mem[col_r]  <= row0 ? luma_r : m;
      mid_mem[col_r] <= luma_r;
    end
  end

  // window, counters and pending results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w1_r <= '0; w2_r <= '0; w3_r <= '0; w4_r <= '0;
      col_r <= '0;
      row_r <= '0;
      pend_r <= '0;
    end else if (restart) begin
      w1_r <= '0; w2_r <= '0; w3_r <= '0; w4_r <= '0;
      col_r <= '0;
      row_r <= '0;
      pend_r <= '0;
    end else begin
      if (cmd.update) begin
        if (!row0) begin
          a_l_r <= w1_r; a_r_r <= m; a_t_r <= w3_r; a_d_r <= w4_r;
          b_l_r <= (col_r == '0) ? m : w2_r;
          b_r_r <= m; b_t_r <= u; b_d_r <= d;
          b_eof_r <= flushing;
          pend_r <= {last, col_r != '0};
        end
        // window cleared once the flush row is done
        if (flushing && last) begin
          w1_r <= '0; w2_r <= '0; w3_r <= '0; w4_r <= '0;
        end else if (!row0) begin
          if (col_r == '0) begin
            w1_r <= m; w2_r <= m;
          end else begin
            w1_r <= w2_r; w2_r <= m;
          end
          w3_r <= u;
          w4_r <= d;
        end
        if (last) begin
          col_r <= '0;
          if (flushing) begin
            row_r <= '0;
          end else begin
            row_r <= row_r + FH_BITS'(1);
          end
        end else begin
          col_r <= col_r + AW'(1);
        end
      end
      if (cmd.pop) begin
        if (pend_r[0]) pend_r[0] <= 1'b0;
        else pend_r[1] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) luma_r <= SB'(in_luma);
  end

  // operand set up
  smp_t sl, sr, st, sd;
  always_comb begin
    if (pend_r[0]) begin
      sl = a_l_r; sr = a_r_r; st = a_t_r; sd = a_d_r;
    end else begin
      sl = b_l_r; sr = b_r_r; st = b_t_r; sd = b_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      adx_r <= (sl > sr) ? sl - sr : sr - sl;
      ady_r <= (st > sd) ? st - sd : sd - st;
      sum_r <= SUMW'(sl) + SUMW'(sr) + SUMW'(st) + SUMW'(sd);
      eol_r <= !pend_r[0];
      eof_r <= !pend_r[0] && b_eof_r;
    end
  end

  // digit-by-digit square root then restoring division
  logic [SW-1:0] s_full;
  logic [RW-1:0] rem_sh, trial;
  logic [DW:0]   dt;
  logic          dge;
  assign s_full = SW'(adx_r) * SW'(adx_r) + SW'(ady_r) * SW'(ady_r);
  assign rem_sh = {rem_r[RW-3:0], sx_r[SXW-1 -: 2]};
  assign trial  = RW'({root_r, 2'b01});
  assign dt     = {rm_r, q_r[NQ-1]};
  assign dge    = dt >= (DW+1)'({sum_r, 1'b0});

  always_ff @(posedge clk) begin
    if (cmd.sq_load || cmd.div_load) cnt_r <= '0;
    else if (cmd.root_step || cmd.div_step) cnt_r <= cnt_r + CNTW'(1);
    if (cmd.sq_load) begin
      sx_r   <= {s_full, {ROOT_FRAC2{1'b0}}};
      root_r <= '0;
      rem_r  <= '0;
    end
    if (cmd.root_step) begin
      sx_r <= {sx_r[SXW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[NP-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[NP-2:0], 1'b0};
      end
    end
    if (cmd.div_load) begin
      q_r  <= NQ'({root_r, 1'b0}) + NQ'(sum_r);
      rm_r <= '0;
    end
    if (cmd.div_step) begin
      rm_r <= dge ? DW'(dt - (DW+1)'({sum_r, 1'b0})) : dt[DW-1:0];
      q_r  <= {q_r[NQ-2:0], dge};
    end
    if (cmd.zero) mag_r <= '0;
    if (cmd.finish) mag_r <= (q_r > NQ'(MAG_MAX)) ? MAG_MAX : q_r[MAG_BITS-1:0];
  end

  always_comb begin
    sts.match     = in_mode == flushing;
    sts.pending   = |pend_r;
    sts.below     = CMPW'(sum_r) <= CMPW'(sum_threshold);
    sts.root_last = cnt_r == CNTW'(NP - 1);
    sts.div_last  = cnt_r == CNTW'(NQ - 1);
  end

  assign magnitude    = mag_r;
  assign end_of_line  = eol_r;
  assign end_of_frame = eof_r;

endmodule

// ----- rtl/relative_gradient_magnitude.sv -----
// Relative gradient magnitude: takes luminance pixels in raster order and returns, for each
// pixel, 2*sqrt(dx^2+dy^2)/sum over its four cross neighbours as unsigned Q2.14, rounded and
// saturated at 2.0, zero where the sum is at or below the threshold. Output for a row appears
// while the next row arrives; one flush item (mode 1) per pixel drains the last row. One item
// is worked on at a time, so a new pixel is not taken until the results of the last one are
// out; each result waits on out_stall and is worked out by the shared one-bit-a-cycle square
// root (SAMPLE_BITS+16 steps) and restoring divider (SAMPLE_BITS+18 steps). Results at or
// below the threshold skip both. A write to any of the three registers restarts the frame.
// depends on rgm_pkg, rgm_ctrl, rgm_dp
module relative_gradient_magnitude
  import rgm_pkg::*;
#(
  parameter int MAX_WIDTH = 2048,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_mode,
  input  logic [15:0]         in_luma,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [MAG_BITS-1:0] out_magnitude,
  output logic                out_end_of_line,
  output logic                out_end_of_frame,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [LW_BITS-1:0]  lw_r;
  logic [FH_BITS-1:0]  fh_r;
  logic [THR_BITS-1:0] thr_r;
  logic                wr;
  reg_idx_t            idx;
  cmd_t                cmd;
  sts_t                sts;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_r  <= LW_BITS'(640);
      fh_r  <= FH_BITS'(480);
      thr_r <= THR_BITS'(7);
    end else if (wr) begin
      case (idx)
        REG_LINE_WIDTH:    lw_r  <= pwdata[LW_BITS-1:0];
        REG_FRAME_HEIGHT:  fh_r  <= pwdata[FH_BITS-1:0];
        REG_SUM_THRESHOLD: thr_r <= pwdata[THR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LINE_WIDTH:    prdata = 32'(lw_r);
      REG_FRAME_HEIGHT:  prdata = 32'(fh_r);
      REG_SUM_THRESHOLD: prdata = 32'(thr_r);
      default:           prdata = '0;
    endcase
  end

  rgm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  rgm_dp #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .restart       (wr && idx != REG_UNUSED),
    .line_width    (lw_r),
    .frame_height  (fh_r),
    .sum_threshold (thr_r),
    .in_mode       (in_mode),
    .in_luma       (in_luma),
    .magnitude     (out_magnitude),
    .end_of_line   (out_end_of_line),
    .end_of_frame  (out_end_of_frame)
  );

  // a request is never taken while a result is on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while result shown");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_magnitude <= MAG_MAX) else $error("magnitude above 2.0");

  a_eof_eol: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_end_of_frame) |-> out_end_of_line)
    else $error("end of frame without end of line");

endmodule

// ----- verif/relative_gradient_magnitude_tb.sv -----
// testbench for relative_gradient_magnitude: raster frames with flush rows, checked
// result by result against a predictor of the line-store and gradient arithmetic
// depends on rgm_pkg and the relative_gradient_magnitude rtl
`timescale 1ns / 100ps

module relative_gradient_magnitude_tb;
  import rgm_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [MAG_BITS-1:0] mag;
    logic                eol;
    logic                eof;
  } grad_res_t;

  typedef struct {
    bit        pinned;
    grad_res_t res;
  } pin_t;

  typedef struct {
    bit          is_cfg;
    reg_idx_t    idx;
    logic [31:0] val;
    logic        mode;
    logic [15:0] luma;
    bit          pinned;
    grad_res_t   res;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_mode = 1'b0;
  logic [15:0]         in_luma = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [MAG_BITS-1:0] out_magnitude;
  logic                out_end_of_line;
  logic                out_end_of_frame;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [3:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  relative_gradient_magnitude i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_mode, .in_luma,
    .out_valid, .out_stall, .out_magnitude, .out_end_of_line, .out_end_of_frame,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [11:0] cfg_width;
  logic [12:0] cfg_height;
  logic [17:0] cfg_thresh;
  logic [15:0] upper_row [2048];
  logic [15:0] middle_row [2048];
  logic [15:0] win [5];
  int unsigned col_pos, row_pos;

  grad_res_t  expected_mags[$];
  pin_t       pin_q[$];
  idle_mode_t idle_mode = IDLE_NONE;
  int         errors = 0;
  bit         hold_req = 1'b0;

  function automatic logic [39:0] root_q15(logic [63:0] s);
    logic [79:0] rad, trial;
    logic [39:0] r;
    rad = {16'b0, s} << 30;
    r = '0;
    for (int b = 39; b >= 0; b--) begin
      trial = {40'b0, r | (40'd1 << b)};
      if (trial * trial <= rad) r = trial[39:0];
    end
    return r;
  endfunction

  function automatic logic [15:0] rel_grad(logic [15:0] l, logic [15:0] r, logic [15:0] t,
                                           logic [15:0] d);
    logic [63:0] adx, ady, sum, q;
    adx = (l > r) ? 64'(l - r) : 64'(r - l);
    ady = (t > d) ? 64'(t - d) : 64'(d - t);
    sum = 64'(l) + 64'(r) + 64'(t) + 64'(d);
    if (sum <= 64'(cfg_thresh)) return '0;
    q = (2 * 64'(root_q15(adx * adx + ady * ady)) + sum) / (2 * sum);
    if (q > 64'(MAG_MAX)) q = 64'(MAG_MAX);
    return q[15:0];
  endfunction

  function automatic int unsigned used_width();
    if (cfg_width == 0) return 1;
    if (cfg_width > 2048) return 2048;
    return cfg_width;
  endfunction

  function automatic int unsigned used_height();
    if (cfg_height == 0) return 1;
    if (cfg_height > 4096) return 4096;
    return cfg_height;
  endfunction

  function automatic void restart_frame();
    foreach (win[i]) win[i] = '0;
    col_pos = 0;
    row_pos = 0;
  endfunction

  function automatic void predict_pixel(logic mode, logic [15:0] luma);
    int unsigned w, c;
    bit flushing, last;
    logic [15:0] m, u, d;
    w = used_width();
    flushing = row_pos >= used_height();
    c = col_pos;
    if (mode != flushing) return;
    if (c >= w) c = w - 1;
    last = (c + 1 >= w);
    if (!flushing && row_pos == 0) begin
      upper_row[c] = luma;
      middle_row[c] = luma;
    end else begin
      m = middle_row[c];
      u = upper_row[c];
      d = flushing ? m : luma;
      if (!flushing) begin
        upper_row[c] = m;
        middle_row[c] = luma;
      end
      if (c == 0) begin
        win[0] = m;
        win[1] = m;
        win[2] = m;
      end else begin
        win[0] = win[1];
        win[1] = win[2];
        win[2] = m;
        expected_mags.push_back('{rel_grad(win[0], win[2], win[3], win[4]), 1'b0, 1'b0});
      end
      if (last) expected_mags.push_back('{rel_grad(win[1], win[2], u, d), 1'b1, flushing});
      win[3] = u;
      win[4] = d;
    end
    if (last) begin
      col_pos = 0;
      if (flushing) restart_frame();
      else row_pos++;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  // request monitor feeds the predictor
  always @(posedge clk) begin
    pin_t p;
    if (rst_n && in_valid && !in_stall) begin
      p = pin_q.pop_front();
      predict_pixel(in_mode, in_luma);
      if (p.pinned && expected_mags.size() > 0) expected_mags[$] = p.res;
    end
  end

  always @(posedge clk) begin
    grad_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_mags.size() == 0) begin
        $error("unexpected result magnitude=%0d", out_magnitude);
        errors++;
      end else begin
        e = expected_mags.pop_front();
        if (out_magnitude !== e.mag) begin
          $error("magnitude: expected %0d, got %0d", e.mag, out_magnitude);
          errors++;
        end
        if (out_end_of_line !== e.eol) begin
          $error("end_of_line: expected %0d, got %0d", e.eol, out_end_of_line);
          errors++;
        end
        if (out_end_of_frame !== e.eof) begin
          $error("end_of_frame: expected %0d, got %0d", e.eof, out_end_of_frame);
          errors++;
        end
      end
    end
  end

  // receiver, with a long hold-off on request so the block backs up
  always @(posedge clk) begin
    int hold_left;
    if (hold_req) begin
      hold_left = 600;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (idle_mode == IDLE_RECV) begin
      out_stall <= ($urandom_range(99) < 88);
    end else if (idle_mode == IDLE_BOTH) begin
      out_stall <= ($urandom_range(99) < 11);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_req(logic mode, logic [15:0] luma, pin_t p);
    int pct;
    pct = (idle_mode == IDLE_SEND) ? 88 : (idle_mode == IDLE_BOTH) ? 11 : 0;
    while ($urandom_range(99) < pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    pin_q.push_back(p);
    in_valid <= 1'b1;
    in_mode <= mode;
    in_luma <= luma;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (expected_mags.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 4'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_LINE_WIDTH:    cfg_width = val[11:0];
      REG_FRAME_HEIGHT:  cfg_height = val[12:0];
      REG_SUM_THRESHOLD: cfg_thresh = val[17:0];
      default: ;
    endcase
    restart_frame();
  endtask

  function automatic logic [15:0] rand_luma();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(31));
      2: return $urandom_range(1) ? 16'hffff : 16'h0000;
      default: return 16'($urandom_range(65535, 65500));
    endcase
  endfunction

  dir_row_t dir_tab[] = '{
    '{1, REG_LINE_WIDTH,    1,      0, 0,      0, '{0, 0, 0}},
    '{1, REG_FRAME_HEIGHT,  1,      0, 0,      0, '{0, 0, 0}},
    '{1, REG_SUM_THRESHOLD, 7,      0, 0,      0, '{0, 0, 0}},
    '{0, REG_UNUSED,        0,      0, 0,      0, '{0, 0, 0}},
    '{0, REG_UNUSED,        0,      1, 0,      1, '{0, 1, 1}},
    // flush while pixels are expected, then pixel while flushing: both ignored
    '{0, REG_UNUSED,        0,      1, 5,      0, '{0, 0, 0}},
    '{0, REG_UNUSED,        0,      0, 65535,  0, '{0, 0, 0}},
    '{0, REG_UNUSED,        0,      0, 1,      0, '{0, 0, 0}},
    '{0, REG_UNUSED,        0,      1, 0,      1, '{0, 1, 1}},
    '{1, REG_LINE_WIDTH,    2,      0, 0,      0, '{0, 0, 0}},
    '{1, REG_FRAME_HEIGHT,  2,      0, 0,      0, '{0, 0, 0}},
    '{1, REG_SUM_THRESHOLD, 0,      0, 0,      0, '{0, 0, 0}},
    '{0, REG_UNUSED,        0,      0, 65535,  0, '{0, 0, 0}},
    '{0, REG_UNUSED,        0,      0, 0,      0, '{0, 0, 0}},
    '{0, REG_UNUSED,        0,      0, 0,      0, '{0, 0, 0}},
    // lone bright left neighbour saturates at 2.0
    '{0, REG_UNUSED,        0,      0, 0,      1, '{16'd32768, 1, 0}},
    '{0, REG_UNUSED,        0,      1, 0,      0, '{0, 0, 0}},
    '{0, REG_UNUSED,        0,      1, 0,      1, '{0, 1, 1}},
    '{1, REG_SUM_THRESHOLD, 262143, 0, 0,      0, '{0, 0, 0}},
    '{1, REG_FRAME_HEIGHT,  0,      0, 0,      0, '{0, 0, 0}},
    '{1, REG_LINE_WIDTH,    0,      0, 0,      0, '{0, 0, 0}},
    '{0, REG_UNUSED,        0,      0, 65535,  0, '{0, 0, 0}},
    '{0, REG_UNUSED,        0,      0, 65535,  0, '{0, 0, 0}},
    '{0, REG_UNUSED,        0,      1, 0,      1, '{0, 1, 1}},
    '{1, REG_LINE_WIDTH,    4095,   0, 0,      0, '{0, 0, 0}},
    '{1, REG_FRAME_HEIGHT,  8191,   0, 0,      0, '{0, 0, 0}},
    '{0, REG_UNUSED,        0,      0, 16'h5a5a, 0, '{0, 0, 0}},
    '{0, REG_UNUSED,        0,      0, 16'ha5a5, 0, '{0, 0, 0}}
  };

  initial begin
    int sent, phase, w, h, frames;
    pin_t nopin;
    nopin = '{0, '{0, 0, 0}};
    cfg_width = 12'd640;
    cfg_height = 13'd480;
    cfg_thresh = 18'd7;
    foreach (upper_row[i]) begin
      upper_row[i] = '0;
      middle_row[i] = '0;
    end
    restart_frame();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        drain();
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        send_req(dir_tab[i].mode, dir_tab[i].luma, '{dir_tab[i].pinned, dir_tab[i].res});
      end
    end

    sent = 0;
    phase = 0;
    while (sent < 1950) begin
      drain();
      idle_mode = idle_mode_t'(phase % 4);
      w = ($urandom_range(4) == 0) ? $urandom_range(48, 7) : $urandom_range(6, 1);
      h = $urandom_range(4, 1);
      write_reg(REG_LINE_WIDTH, w);
      write_reg(REG_FRAME_HEIGHT, h);
      case ($urandom_range(4))
        0: write_reg(REG_SUM_THRESHOLD, 0);
        1: write_reg(REG_SUM_THRESHOLD, $urandom_range(262143));
        2: write_reg(REG_SUM_THRESHOLD, 262143);
        default: write_reg(REG_SUM_THRESHOLD, $urandom_range(40));
      endcase
      if (phase == 2) hold_req = 1'b1;
      frames = $urandom_range(3, 1);
      repeat (frames) begin
        for (int r = 0; r <= h; r++) begin
          for (int c = 0; c < w; c++) begin
            // stray request of the wrong kind, dropped by the block
            if ($urandom_range(99) < 6) send_req(r < h, 16'($urandom), nopin);
            send_req(r == h, rand_luma(), nopin);
            sent++;
          end
        end
      end
      phase++;
    end

    drain();
    if (errors == 0) $display("relative_gradient_magnitude_tb: clean");
    else $display("relative_gradient_magnitude_tb: errors");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("relative_gradient_magnitude_tb: errors");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/rgm_pkg.sv
rtl/rgm_ctrl.sv
rtl/rgm_dp.sv
rtl/relative_gradient_magnitude.sv
verif/relative_gradient_magnitude_tb.sv
